@@ rtl/core/cesd_pkg.sv @@
// Shared types and character codes for the C escape sequence decoder.
package cesd_pkg;

   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_V         = 8'h76;
   localparam logic [7:0] CH_B         = 8'h62;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_A         = 8'h61;
   localparam logic [7:0] CH_X         = 8'h78;
   localparam logic [7:0] CH_EIGHT     = 8'h38;
   localparam logic [7:0] CH_NINE      = 8'h39;

   localparam logic [7:0] CODE_LF  = 8'd10;
   localparam logic [7:0] CODE_TAB = 8'd9;
   localparam logic [7:0] CODE_VT  = 8'd11;
   localparam logic [7:0] CODE_BS  = 8'd8;
   localparam logic [7:0] CODE_CR  = 8'd13;
   localparam logic [7:0] CODE_BEL = 8'd7;

   // One queued step: one or two results.
   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic       pair;     // second result present (always carries a byte)
      logic       valid0;   // first result carries a byte
      logic       eos;      // last result of this step ends the string
   } cesd_entry_type;

   typedef struct packed {
      logic           push;
      cesd_entry_type entry;
   } cesd_push_type;

endpackage

@@ rtl/core/cesd_req_if.sv @@
// Input channel: one source byte per transfer.
interface cesd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       is_last;

   modport source (output valid, output in_byte, output is_last, input ready);
   modport sink (input valid, input in_byte, input is_last, output ready);
endinterface

@@ rtl/core/cesd_rsp_if.sv @@
// Result channel: one decoded byte or end marker per transfer.
interface cesd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       end_of_string;

   modport source (output valid, output out_byte, output byte_valid,
                   output end_of_string, input ready);
   modport sink (input valid, input out_byte, input byte_valid,
                 input end_of_string, output ready);
endinterface

@@ rtl/core/cesd_front.sv @@
// Front end: accepts source bytes, tracks escape state, builds queue entries.
module cesd_front (
   input  logic                   clock,
   input  logic                   reset,
   cesd_req_if.sink               req_bus,
   input  logic                   queue_full,
   output cesd_pkg::cesd_push_type push_out
);

   localparam logic [1:0] MODE_TEXT = 2'd0;
   localparam logic [1:0] MODE_ESC  = 2'd1;
   localparam logic [1:0] MODE_HEX  = 2'd2;
   localparam logic [1:0] MODE_OCT  = 2'd3;

   logic [1:0] mode_ff, mode_in;
   logic [7:0] run_ff, run_in;
   logic       accept;
   logic [7:0] c;
   logic       is_oct;
   logic       is_hex;
   logic [3:0] hex_val;
   logic [1:0] cnt;
   logic [7:0] b0, b1;
   logic       valid0;

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !queue_full;
   assign c             = req_bus.in_byte;

   always_comb begin
      is_oct  = (c >= 8'h30) && (c <= 8'h37);
      is_hex  = 1'b1;
      hex_val = c[3:0];
      if ((c >= 8'h30) && (c <= 8'h39)) begin
         hex_val = c[3:0];
      end else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46))) begin
         hex_val = c[3:0] + 4'd9;
      end else begin
         is_hex = 1'b0;
      end
   end

   always_comb begin
      mode_in = mode_ff;
      run_in  = run_ff;
      cnt     = 2'd0;
      b0      = 8'd0;
      b1      = 8'd0;
      valid0  = 1'b1;
      case (mode_ff)
         MODE_TEXT: begin
            if (c == cesd_pkg::CH_BACKSLASH) begin
               mode_in = MODE_ESC;
            end else begin
               b0  = c;
               cnt = 2'd1;
            end
         end
         MODE_ESC: begin
            mode_in = MODE_TEXT;
            cnt     = 2'd1;
            case (c)
               cesd_pkg::CH_N: b0 = cesd_pkg::CODE_LF;
               cesd_pkg::CH_T: b0 = cesd_pkg::CODE_TAB;
               cesd_pkg::CH_V: b0 = cesd_pkg::CODE_VT;
               cesd_pkg::CH_B: b0 = cesd_pkg::CODE_BS;
               cesd_pkg::CH_R: b0 = cesd_pkg::CODE_CR;
               cesd_pkg::CH_A: b0 = cesd_pkg::CODE_BEL;
               cesd_pkg::CH_X: begin
                  mode_in = MODE_HEX;
                  run_in  = 8'd0;
                  cnt     = 2'd0;
               end
               cesd_pkg::CH_EIGHT, cesd_pkg::CH_NINE: begin
                  b0  = 8'd0;
                  b1  = c;
                  cnt = 2'd2;
               end
               default: begin
                  if (is_oct) begin
                     mode_in = MODE_OCT;
                     run_in  = {5'd0, c[2:0]};
                     cnt     = 2'd0;
                  end else begin
                     b0 = c;
                  end
               end
            endcase
         end
         default: begin
            // Hex or octal run: extend it, or close it and treat c as text.
            if ((mode_ff == MODE_HEX) && is_hex) begin
               run_in = {run_ff[3:0], hex_val};
            end else if ((mode_ff == MODE_OCT) && is_oct) begin
               run_in = {run_ff[4:0], c[2:0]};
            end else begin
               mode_in = MODE_TEXT;
               b0      = run_ff;
               if (c == cesd_pkg::CH_BACKSLASH) begin
                  mode_in = MODE_ESC;
                  cnt     = 2'd1;
               end else begin
                  b1  = c;
                  cnt = 2'd2;
               end
            end
         end
      endcase

      if (req_bus.is_last) begin
         // An open run leaves nothing else pending in this step: flush it.
         if ((mode_in == MODE_HEX) || (mode_in == MODE_OCT)) begin
            b0  = run_in;
            cnt = 2'd1;
         end
         if (cnt == 2'd0) begin
            b0     = 8'd0;
            valid0 = 1'b0;
            cnt    = 2'd1;
         end
         mode_in = MODE_TEXT;
         run_in  = 8'd0;
      end
   end

   always_comb begin
      push_out.push         = accept && (cnt != 2'd0);
      push_out.entry.byte0  = b0;
      push_out.entry.byte1  = b1;
      push_out.entry.pair   = (cnt == 2'd2);
      push_out.entry.valid0 = valid0;
      push_out.entry.eos    = req_bus.is_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_TEXT;
         run_ff  <= 8'd0;
      end else if (accept) begin
         mode_ff <= mode_in;
         run_ff  <= run_in;
      end
   end

endmodule

@@ rtl/core/cesd_queue.sv @@
// Two-entry queue between front end and back end.
module cesd_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  cesd_pkg::cesd_push_type  push_in,
   input  logic                     pop,
   output logic                     full,
   output logic                     head_valid,
   output cesd_pkg::cesd_entry_type head
);

   cesd_pkg::cesd_entry_type mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_pop;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head       = mem[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_in.push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, push_in.push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (push_in.push) begin
         mem[wr_ptr_ff] <= push_in.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/core/cesd_back.sv @@
// Back end: expands queue entries into result transfers through an output register.
module cesd_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  cesd_pkg::cesd_entry_type head,
   output logic                     pop,
   cesd_rsp_if.source               rsp_bus
);

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       bv_ff, bv_in;
   logic       eos_ff, eos_in;
   logic       phase_ff, phase_in;
   logic       load;
   logic       take;

   assign load = !rsp_valid_ff || rsp_bus.ready;
   assign take = load && head_valid;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      byte_in      = byte_ff;
      bv_in        = bv_ff;
      eos_in       = eos_ff;
      phase_in     = phase_ff;
      pop          = 1'b0;
      if (take) begin
         rsp_valid_in = 1'b1;
         if (head.pair && !phase_ff) begin
            // First of two: hold the entry for the second.
            byte_in  = head.byte0;
            bv_in    = 1'b1;
            eos_in   = 1'b0;
            phase_in = 1'b1;
         end else if (head.pair) begin
            byte_in  = head.byte1;
            bv_in    = 1'b1;
            eos_in   = head.eos;
            phase_in = 1'b0;
            pop      = 1'b1;
         end else begin
            byte_in  = head.byte0;
            bv_in    = head.valid0;
            eos_in   = head.eos;
            phase_in = 1'b0;
            pop      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      bv_ff   <= bv_in;
      eos_ff  <= eos_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.out_byte      = byte_ff;
   assign rsp_bus.byte_valid    = bv_ff;
   assign rsp_bus.end_of_string = eos_ff;

endmodule

@@ rtl/core/c_escape_sequence_decoder_core.sv @@
// Top level of the C escape sequence decoder: front end, queue and back end.
//
//   channel   direction  payload                               transfer when
//   req_bus   in         in_byte[7:0], is_last                 valid && ready
//   rsp_bus   out        out_byte[7:0], byte_valid, end_of_str valid && ready
//
// One source byte is taken per cycle while the two-entry queue has room.
// A byte that yields two results (closed run plus next byte, or backslash
// then 8 or 9) keeps its queue entry until the result register has taken
// both results, so a stream of such bytes slows intake; all others run at
// one. A result is registered in the queue, then in the result register.
// Reset is synchronous: escape state returns to plain text, queue and
// result register empty. A stalled result side fills the queue and then
// drops req_bus.ready; the front end never stalls the back end.
module c_escape_sequence_decoder_core (
   input  logic       clock,
   input  logic       reset,
   cesd_req_if.sink   req_bus,
   cesd_rsp_if.source rsp_bus
);

   cesd_pkg::cesd_push_type  push;
   cesd_pkg::cesd_entry_type head;
   logic                     queue_full;
   logic                     head_valid;
   logic                     pop;

   // Classify each byte and advance the escape state.
   cesd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .queue_full (queue_full),
      .push_out   (push)
   );

   // Decouple the two sides so either may stall alone.
   cesd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_in    (push),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head       (head)
   );

   // Issue one result per cycle from the queue head while rsp_bus is ready.
   cesd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

@@ tb/sv/tb_c_escape_sequence_decoder_core.sv @@
// Self-checking testbench for the C escape sequence decoder core.
`timescale 1ns / 100ps

module tb_c_escape_sequence_decoder_core;

   // Characters the testbench uses that the package does not name.
   localparam logic [7:0] CH_QUESTION = 8'h3F;
   localparam logic [7:0] CH_SQUOTE   = 8'h27;
   localparam logic [7:0] CH_DQUOTE   = 8'h22;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_SEVEN    = 8'h37;
   localparam logic [7:0] CH_LC_A     = 8'h61;
   localparam logic [7:0] CH_LC_F     = 8'h66;
   localparam logic [7:0] CH_UC_A     = 8'h41;
   localparam logic [7:0] CH_UC_F     = 8'h46;
   localparam logic [7:0] CH_UC_G     = 8'h47;

   localparam int ITEM_TARGET   = 1550;
   localparam int HOLD_CYCLES   = 250;
   localparam int DRAIN_CYCLES  = 20;
   localparam int MAX_REPORTS   = 10;

   typedef enum logic [1:0] {
      MD_TEXT,
      MD_ESC,
      MD_HEX,
      MD_OCT
   } decode_mode_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       end_of_string;
   } decoded_type;

   // Escape decoder prediction plus the queue of decoded bytes still owed.
   class escape_scoreboard;
      decode_mode_type mode;
      logic [7:0]      run_value;
      decoded_type     owed_q[$];
      decoded_type     step_out[$];
      int              mismatches;

      function new();
         mode       = MD_TEXT;
         run_value  = 8'h00;
         mismatches = 0;
      endfunction

      function void emit(logic [7:0] b);
         step_out.insert(step_out.size(), decoded_type'{b, 1'b1, 1'b0});
      endfunction

      // Handle a byte as ordinary text: a backslash opens an escape.
      function void take_text(logic [7:0] c);
         if (c == cesd_pkg::CH_BACKSLASH) begin
            mode = MD_ESC;
         end else begin
            emit(c);
         end
      endfunction

      // Decode one accepted source byte and queue the results it owes.
      function void note_input(logic [7:0] c, logic last);
         logic [3:0] nib;
         logic       is_hex;
         step_out.delete();
         case (mode)
            MD_TEXT: begin
               take_text(c);
            end
            MD_ESC: begin
               mode = MD_TEXT;
               case (c)
                  cesd_pkg::CH_N: emit(cesd_pkg::CODE_LF);
                  cesd_pkg::CH_T: emit(cesd_pkg::CODE_TAB);
                  cesd_pkg::CH_V: emit(cesd_pkg::CODE_VT);
                  cesd_pkg::CH_B: emit(cesd_pkg::CODE_BS);
                  cesd_pkg::CH_R: emit(cesd_pkg::CODE_CR);
                  cesd_pkg::CH_A: emit(cesd_pkg::CODE_BEL);
                  CH_QUESTION, CH_SQUOTE, CH_DQUOTE, cesd_pkg::CH_BACKSLASH: emit(c);
                  cesd_pkg::CH_X: begin
                     mode      = MD_HEX;
                     run_value = 8'h00;
                  end
                  default: begin
                     if (c >= CH_ZERO && c <= CH_SEVEN) begin
                        mode      = MD_OCT;
                        run_value = {5'd0, c[2:0]};
                     end else if (c == cesd_pkg::CH_EIGHT || c == cesd_pkg::CH_NINE) begin
                        emit(8'h00);
                        emit(c);
                     end else begin
                        // unknown escape: drop the backslash
                        emit(c);
                     end
                  end
               endcase
            end
            MD_HEX: begin
               is_hex = 1'b1;
               nib    = 4'd0;
               if (c >= CH_ZERO && c <= cesd_pkg::CH_NINE) begin
                  nib = c[3:0];
               end else if (c >= CH_LC_A && c <= CH_LC_F) begin
                  nib = 4'(c - CH_LC_A + 8'd10);
               end else if (c >= CH_UC_A && c <= CH_UC_F) begin
                  nib = 4'(c - CH_UC_A + 8'd10);
               end else begin
                  is_hex = 1'b0;
               end
               if (is_hex) begin
                  run_value = {run_value[3:0], nib};
               end else begin
                  mode = MD_TEXT;
                  emit(run_value);
                  take_text(c);
               end
            end
            default: begin
               if (c >= CH_ZERO && c <= CH_SEVEN) begin
                  run_value = {run_value[4:0], c[2:0]};
               end else begin
                  mode = MD_TEXT;
                  emit(run_value);
                  take_text(c);
               end
            end
         endcase

         if (last) begin
            // flush an open run; a lone trailing backslash just vanishes
            if (mode == MD_HEX || mode == MD_OCT) begin
               emit(run_value);
            end
            if (step_out.size() == 0) begin
               step_out.insert(0, decoded_type'{8'h00, 1'b0, 1'b1});
            end else begin
               step_out[step_out.size() - 1].end_of_string = 1'b1;
            end
            mode      = MD_TEXT;
            run_value = 8'h00;
         end

         foreach (step_out[i]) begin
            owed_q.insert(owed_q.size(), step_out[i]);
         end
      endfunction

      // Compare one accepted result with the oldest owed one.
      function void check_result(decoded_type got);
         decoded_type want;
         if (owed_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("unexpected result: byte %02h valid %0b eos %0b",
                        got.out_byte, got.byte_valid, got.end_of_string);
            end
            return;
         end
         want = owed_q.pop_front();
         if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
             got.end_of_string !== want.end_of_string) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("mismatch: expected byte %02h valid %0b eos %0b,",
                        want.out_byte, want.byte_valid, want.end_of_string,
                        " got byte %02h valid %0b eos %0b",
                        got.out_byte, got.byte_valid, got.end_of_string);
            end
         end
      endfunction

      function int pending();
         return owed_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   cesd_req_if req_bus ();
   cesd_rsp_if rsp_bus ();

   c_escape_sequence_decoder_core DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   escape_scoreboard sb = new();

   int bit_sent;            // count of source bytes accepted by the decoder
   bit quiet_stretch;       // suppress random idling on both sides
   bit hold_request;        // ask the receiver for one long hold-off
   logic [7:0] string_q[$];

   always #2 clock = ~clock;

   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.in_byte   = 8'h00;
      req_bus.is_last   = 1'b0;
      rsp_bus.ready     = 1'b0;
      quiet_stretch     = 1'b0;
      hold_request      = 1'b0;
      bit_sent          = 0;
   end

   // Sample both channels at the rising edge; note inputs, check results.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            sb.check_result(decoded_type'{rsp_bus.out_byte, rsp_bus.byte_valid,
                                          rsp_bus.end_of_string});
         end
         if (req_bus.valid && req_bus.ready) begin
            sb.note_input(req_bus.in_byte, req_bus.is_last);
         end
      end
   end

   // Receiver: idle at random, and hold off for a long stretch on request.
   initial begin : result_sink
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!quiet_stretch && $urandom_range(0, 99) < 6) begin
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Offer one source byte and hold it until the transfer happens.
   task automatic send_byte(input logic [7:0] b, input logic last);
      @(negedge clock);
      while (!quiet_stretch && $urandom_range(0, 99) < 6) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.in_byte <= b;
      req_bus.is_last <= last;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      bit_sent++;
   endtask

   // Append one byte to the staged string.
   function automatic void stage_byte(logic [7:0] b);
      string_q.insert(string_q.size(), b);
   endfunction

   // Send the staged string, marking its final byte.
   task automatic send_string();
      foreach (string_q[i]) begin
         send_byte(string_q[i], i == string_q.size() - 1);
      end
      string_q.delete();
   endtask

   // Stage one hex digit in random case.
   task automatic stage_hex_digit();
      logic [3:0] d;
      d = 4'($urandom_range(0, 15));
      if (d < 10) begin
         stage_byte(CH_ZERO + 8'(d));
      end else if ($urandom_range(0, 1) == 0) begin
         stage_byte(CH_LC_A + 8'(d - 10));
      end else begin
         stage_byte(CH_UC_A + 8'(d - 10));
      end
   endtask

   // Stage a random string made of escape tokens and text.
   task automatic stage_random_string();
      int tokens;
      int kind;
      int digits;
      tokens = $urandom_range(1, 6);
      repeat (tokens) begin
         kind = $urandom_range(0, 99);
         if (kind < 30) begin
            stage_byte(8'($urandom_range(32, 126)));
         end else if (kind < 45) begin
            stage_byte(cesd_pkg::CH_BACKSLASH);
            case ($urandom_range(0, 9))
               0: stage_byte(cesd_pkg::CH_N);
               1: stage_byte(cesd_pkg::CH_T);
               2: stage_byte(cesd_pkg::CH_V);
               3: stage_byte(cesd_pkg::CH_B);
               4: stage_byte(cesd_pkg::CH_R);
               5: stage_byte(cesd_pkg::CH_A);
               6: stage_byte(CH_QUESTION);
               7: stage_byte(CH_SQUOTE);
               8: stage_byte(CH_DQUOTE);
               default: stage_byte(cesd_pkg::CH_BACKSLASH);
            endcase
         end else if (kind < 60) begin
            stage_byte(cesd_pkg::CH_BACKSLASH);
            stage_byte(cesd_pkg::CH_X);
            digits = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 9) : $urandom_range(0, 4);
            repeat (digits) stage_hex_digit();
         end else if (kind < 72) begin
            stage_byte(cesd_pkg::CH_BACKSLASH);
            repeat ($urandom_range(1, 5)) begin
               stage_byte(CH_ZERO + 8'($urandom_range(0, 7)));
            end
         end else if (kind < 78) begin
            stage_byte(cesd_pkg::CH_BACKSLASH);
            stage_byte($urandom_range(0, 1) ? cesd_pkg::CH_EIGHT : cesd_pkg::CH_NINE);
         end else if (kind < 88) begin
            stage_byte(cesd_pkg::CH_BACKSLASH);
            stage_byte(8'($urandom_range(0, 255)));
         end else begin
            stage_byte(8'($urandom_range(0, 255)));
         end
      end
      // now and then end on a lone backslash
      if ($urandom_range(0, 19) == 0) begin
         stage_byte(cesd_pkg::CH_BACKSLASH);
      end
   endtask

   initial begin : stimulus
      int drain;
      int hold_at;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: a two-byte string of the extreme bytes.
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      // Empty hex run closed by the end of the string.
      send_byte(cesd_pkg::CH_BACKSLASH, 1'b0);
      send_byte(cesd_pkg::CH_X, 1'b1);
      // Empty hex run closed by a non-hex byte.
      send_byte(cesd_pkg::CH_BACKSLASH, 1'b0);
      send_byte(cesd_pkg::CH_X, 1'b0);
      send_byte(CH_UC_G, 1'b0);
      // Backslash then nine on the last byte: two results, marker on the second.
      send_byte(cesd_pkg::CH_BACKSLASH, 1'b0);
      send_byte(cesd_pkg::CH_NINE, 1'b1);
      // Unknown escape drops the backslash.
      send_byte(cesd_pkg::CH_BACKSLASH, 1'b0);
      send_byte(CH_LC_F, 1'b0);
      // Long hex run keeps the low byte and flushes at the end.
      send_byte(cesd_pkg::CH_BACKSLASH, 1'b0);
      send_byte(cesd_pkg::CH_X, 1'b0);
      send_byte(CH_ZERO + 8'd1, 1'b0);
      send_byte(CH_ZERO + 8'd2, 1'b0);
      send_byte(CH_ZERO + 8'd3, 1'b1);
      // Octal overflow, closed by a letter that is also the last byte.
      send_byte(cesd_pkg::CH_BACKSLASH, 1'b0);
      send_byte(CH_SEVEN, 1'b0);
      send_byte(CH_SEVEN, 1'b0);
      send_byte(CH_SEVEN, 1'b0);
      send_byte(CH_UC_A, 1'b1);
      // Trailing lone backslash yields an empty end marker.
      send_byte(cesd_pkg::CH_BACKSLASH, 1'b1);
      send_byte(cesd_pkg::CH_BACKSLASH, 1'b0);
      send_byte(cesd_pkg::CH_N, 1'b1);

      // Random strings; one long receiver hold-off and one quiet stretch.
      hold_at = $urandom_range(250, 450);
      while (bit_sent < ITEM_TARGET) begin
         if (bit_sent >= hold_at && hold_at > 0) begin
            hold_request = 1'b1;
            hold_at      = 0;
         end
         quiet_stretch = (bit_sent >= 700 && bit_sent < 1000);
         if ($urandom_range(0, 9) == 0) begin
            // noise: raw bytes with a random end flag
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end else begin
            stage_random_string();
            send_string();
         end
      end

      @(negedge clock);
      req_bus.valid   <= 1'b0;
      quiet_stretch   = 1'b0;

      // Drain everything owed, then give stray results a chance to show.
      while (sb.pending() > 0) begin
         @(negedge clock);
      end
      for (drain = 0; drain < DRAIN_CYCLES; drain++) begin
         @(negedge clock);
      end

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("c_escape_sequence_decoder_core test passed");
      end else begin
         $display("c_escape_sequence_decoder_core test failed");
      end
      $finish;
   end

   // Watchdog: stop a hung run.
   initial begin
      #400000;
      $display("c_escape_sequence_decoder_core test failed");
      $finish;
   end

endmodule

@@ c_escape_sequence_decoder_core.f @@
rtl/core/cesd_pkg.sv
rtl/core/cesd_req_if.sv
rtl/core/cesd_rsp_if.sv
rtl/core/cesd_front.sv
rtl/core/cesd_queue.sv
rtl/core/cesd_back.sv
rtl/core/c_escape_sequence_decoder_core.sv
tb/sv/tb_c_escape_sequence_decoder_core.sv
